[rtl/rast_pkg.sv]
// ----------------------------------------------------------------------------
// rast_pkg - shared types and constants for the range add / range sum tree
// Position and node index widths, request and status codes, and the control
// bundles that run between the sequencer, the arithmetic unit and the RAMs.
// ----------------------------------------------------------------------------
package rast_pkg;

  // Geometry: positions are POS_W bits, the tree has 2*LEAVES nodes
  localparam int POS_W  = 10;
  localparam int LEAVES = 1 << POS_W;
  localparam int NODES  = 2 * LEAVES;
  localparam int NODE_W = POS_W + 1;
  localparam int CNT_W  = POS_W + 1;
  localparam int DATA_W = 32;

  // Last usable position; position 0 and LEAVES-1 are boundary slots
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LEAVES - 2);

  // Request codes
  localparam logic [1:0] REQ_POINT_ADD = 2'd0;
  localparam logic [1:0] REQ_RANGE_ADD = 2'd1;
  localparam logic [1:0] REQ_RANGE_SUM = 2'd2;

  // Status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // Arithmetic unit controls
  typedef struct packed {
    logic mul_load;   // capture count * operand into the product register
    logic mul_mem;    // multiplier operand comes from RAM (else the amount)
    logic use_prod;   // adder takes the product as second operand
    logic acc_mode;   // query: adder works on the accumulator
    logic acc_clear;  // new request: zero the accumulator
    logic acc_load;   // store adder result in the accumulator
    logic lazy_sel;   // read data comes from the lazy-mark RAM
  } alu_ctrl_t;

  // RAM controls; both RAMs share one address
  typedef struct packed {
    logic              rd_en;
    logic              node_we;
    logic              lazy_we;
    logic              wr_zero;   // clearing pass writes zeros
    logic [NODE_W-1:0] addr;
  } mem_ctrl_t;

endpackage

[rtl/range_add_range_sum_tree_unit.sv]
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_unit - bottom-up range add / range sum tree
// Point add, range add and range sum over 1022 positions with node sums
// and never-pushed lazy marks held in two 2048 x 32 RAMs.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  request   | start / busy       | req_type, left_pos, right_pos, amount
//  result    | done (1-cycle)     | range_sum, status
//
//  A request beat is taken when start is high and busy is low.
//  Each node access runs through ST_ISSUE and ST_ADD, with ST_MUL between them
//  when it goes through the multiplier, plus one ST_LEVEL loop test per level;
//  a request keeps busy high while climbing from the leaves to the root, one
//  RAM access at a time. Bad or ignored requests finish at once.
//  After reset a clearing pass zeroes the RAMs: busy is high until all nodes are cleared.
//  A query result is on the ports for one cycle with done; it cannot stall.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_unit import rast_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type,
  input  logic [POS_W-1:0]  left_pos,
  input  logic [POS_W-1:0]  right_pos,
  input  logic [DATA_W-1:0] amount,
  output logic              done,
  output logic [DATA_W-1:0] range_sum,
  output logic              status
);

  alu_ctrl_t         alu_ctrl;
  mem_ctrl_t         mem_ctrl;
  logic [CNT_W-1:0]  mul_cnt;
  logic [DATA_W-1:0] k;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W-1:0] node_rd;
  logic [DATA_W-1:0] lazy_rd;

  // Sequencer
  rast_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req_type  (req_type),
    .left_pos  (left_pos),
    .right_pos (right_pos),
    .amount    (amount),
    .acc       (acc),
    .busy      (busy),
    .done      (done),
    .range_sum (range_sum),
    .status    (status),
    .alu_ctrl  (alu_ctrl),
    .mul_cnt   (mul_cnt),
    .k         (k),
    .mem_ctrl  (mem_ctrl)
  );

  // Shared multiply / add unit
  rast_alu u_alu (
    .clk     (clk),
    .ctrl    (alu_ctrl),
    .node_rd (node_rd),
    .lazy_rd (lazy_rd),
    .cnt     (mul_cnt),
    .k       (k),
    .sum     (sum),
    .acc     (acc)
  );

  assign wr_data = mem_ctrl.wr_zero ? '0 : sum;

  // Node sum store
  rast_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_ctrl.node_we),
    .waddr (mem_ctrl.addr),
    .wdata (wr_data),
    .re    (mem_ctrl.rd_en),
    .raddr (mem_ctrl.addr),
    .rdata (node_rd)
  );

  // Lazy mark store
  rast_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NODES)
  ) u_lazy_ram (
    .clk   (clk),
    .we    (mem_ctrl.lazy_we),
    .waddr (mem_ctrl.addr),
    .wdata (wr_data),
    .re    (mem_ctrl.rd_en),
    .raddr (mem_ctrl.addr),
    .rdata (lazy_rd)
  );

`ifndef SYNTHESIS
  // A result only shows up once the walk is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // RAMs are only written during work
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(mem_ctrl.node_we || mem_ctrl.lazy_we))
    else $error("RAM write while idle");

  // Both RAMs written together only by the clearing pass
  a_dual_write: assert property (@(posedge clk) disable iff (rst)
    (mem_ctrl.node_we && mem_ctrl.lazy_we) |-> mem_ctrl.wr_zero)
    else $error("both RAMs written outside clearing pass");

  // Reading never overlaps a write-back
  a_rd_wr: assert property (@(posedge clk) disable iff (rst)
    mem_ctrl.rd_en |-> !(mem_ctrl.node_we || mem_ctrl.lazy_we))
    else $error("RAM read and write in the same cycle");
`endif

endmodule

[rtl/rast_ram.sv]
// ----------------------------------------------------------------------------
// rast_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module rast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rast_alu.sv]
// ----------------------------------------------------------------------------
// rast_alu - shared multiply / add unit
// A registered count-by-word multiplier followed by one 32-bit adder that
// either updates a RAM word or the query accumulator.
// ----------------------------------------------------------------------------
module rast_alu import rast_pkg::*; (
  input  logic              clk,
  input  alu_ctrl_t         ctrl,
  input  logic [DATA_W-1:0] node_rd,
  input  logic [DATA_W-1:0] lazy_rd,
  input  logic [CNT_W-1:0]  cnt,
  input  logic [DATA_W-1:0] k,
  output logic [DATA_W-1:0] sum,
  output logic [DATA_W-1:0] acc
);

  logic [DATA_W-1:0]       rd;
  logic [DATA_W-1:0]       mul_b;
  logic [CNT_W+DATA_W-1:0] prod_full;
  logic [DATA_W-1:0]       prod;
  logic [DATA_W-1:0]       add_a;
  logic [DATA_W-1:0]       add_b;

  // Operand selection
  assign rd        = ctrl.lazy_sel ? lazy_rd : node_rd;
  assign mul_b     = ctrl.mul_mem ? rd : k;
  assign prod_full = {{DATA_W{1'b0}}, cnt} * {{CNT_W{1'b0}}, mul_b};

  // Product register, wraps to 32 bits
  always_ff @(posedge clk) begin
    if (ctrl.mul_load) begin
      prod <= prod_full[DATA_W-1:0];
    end
  end

  // Shared adder
  assign add_a = ctrl.acc_mode ? acc : rd;
  assign add_b = ctrl.use_prod ? prod : (ctrl.acc_mode ? rd : k);
  assign sum   = add_a + add_b;

  // Query accumulator
  always_ff @(posedge clk) begin
    if (ctrl.acc_clear) begin
      acc <= '0;
    end else if (ctrl.acc_load) begin
      acc <= sum;
    end
  end

endmodule

[rtl/rast_seq.sv]
// ----------------------------------------------------------------------------
// rast_seq - request sequencer
// Clears the RAMs after reset, checks requests, walks the two boundary
// paths level by level and steps through the node accesses of each level.
// ----------------------------------------------------------------------------
module rast_seq import rast_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  logic [POS_W-1:0]  left_pos,
  input  logic [POS_W-1:0]  right_pos,
  input  logic [DATA_W-1:0] amount,
  input  logic [DATA_W-1:0] acc,
  output logic              busy,
  output logic              done,
  output logic [DATA_W-1:0] range_sum,
  output logic              status,
  output alu_ctrl_t         alu_ctrl,
  output logic [CNT_W-1:0]  mul_cnt,
  output logic [DATA_W-1:0] k,
  output mem_ctrl_t         mem_ctrl
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_LEVEL = 6'b000100,
    ST_ISSUE = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_ADD   = 6'b100000
  } state_t;

  // Node accesses within one level
  typedef enum logic [2:0] {
    OP_S  = 3'd0,   // boundary node s
    OP_T  = 3'd1,   // boundary node t
    OP_SN = 3'd2,   // sum of sibling of s
    OP_SL = 3'd3,   // lazy mark of sibling of s
    OP_TN = 3'd4,   // sum of sibling of t
    OP_TL = 3'd5    // lazy mark of sibling of t
  } op_t;

  state_t            state;
  op_t               op;
  op_t               op_nxt;
  logic              op_more;
  logic              op_lazy;
  logic              op_mul;
  logic [NODE_W-1:0] op_addr;
  logic [NODE_W-1:0] clr_addr;
  logic [NODE_W-1:0] s;
  logic [NODE_W-1:0] t;
  logic [CNT_W-1:0]  cl;
  logic [CNT_W-1:0]  cr;
  logic [CNT_W-1:0]  len;
  logic              is_query;
  logic              phase2;
  logic              accept;
  logic              pos_ok;
  logic              range_ok;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign pos_ok   = (left_pos != '0) && (left_pos <= LAST_POS);
  assign range_ok = (left_pos != '0) && (left_pos <= right_pos) && (right_pos <= LAST_POS);

  // Access attributes and the following access in this level
  always_comb begin
    op_addr = s;
    op_lazy = 1'b0;
    op_mul  = 1'b0;
    mul_cnt = len;
    op_more = 1'b0;
    op_nxt  = OP_S;
    case (op)
      OP_S: begin
        op_addr = s;
        op_lazy = is_query;
        op_mul  = 1'b1;
        mul_cnt = cl;
        op_more = 1'b1;
        op_nxt  = OP_T;
      end
      OP_T: begin
        op_addr = t;
        op_lazy = is_query;
        op_mul  = 1'b1;
        mul_cnt = cr;
        if (!phase2 && !s[0]) begin
          op_more = 1'b1;
          op_nxt  = OP_SN;
        end else if (!phase2 && t[0]) begin
          op_more = 1'b1;
          op_nxt  = OP_TN;
        end
      end
      OP_SN: begin
        op_addr = s ^ NODE_W'(1);
        op_mul  = !is_query;
        if (!is_query) begin
          op_more = 1'b1;
          op_nxt  = OP_SL;
        end else if (t[0]) begin
          op_more = 1'b1;
          op_nxt  = OP_TN;
        end
      end
      OP_SL: begin
        op_addr = s ^ NODE_W'(1);
        op_lazy = 1'b1;
        if (t[0]) begin
          op_more = 1'b1;
          op_nxt  = OP_TN;
        end
      end
      OP_TN: begin
        op_addr = t ^ NODE_W'(1);
        op_mul  = !is_query;
        if (!is_query) begin
          op_more = 1'b1;
          op_nxt  = OP_TL;
        end
      end
      OP_TL: begin
        op_addr = t ^ NODE_W'(1);
        op_lazy = 1'b1;
      end
      default: begin
        op_addr = s;
      end
    endcase
  end

  // Arithmetic unit controls
  always_comb begin
    alu_ctrl.mul_load  = (state == ST_MUL);
    alu_ctrl.mul_mem   = is_query;
    alu_ctrl.use_prod  = op_mul;
    alu_ctrl.acc_mode  = is_query;
    alu_ctrl.acc_clear = accept;
    alu_ctrl.acc_load  = (state == ST_ADD) && is_query;
    alu_ctrl.lazy_sel  = op_lazy;
  end

  // RAM controls
  always_comb begin
    mem_ctrl.rd_en   = (state == ST_ISSUE);
    mem_ctrl.wr_zero = (state == ST_CLEAR);
    mem_ctrl.node_we = (state == ST_CLEAR) || ((state == ST_ADD) && !is_query && !op_lazy);
    mem_ctrl.lazy_we = (state == ST_CLEAR) || ((state == ST_ADD) && !is_query && op_lazy);
    mem_ctrl.addr    = (state == ST_CLEAR) ? clr_addr : op_addr;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      case (state)
        // zero both RAMs, one node per cycle
        ST_CLEAR: begin
          done     <= 1'b0;
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end

        // take a request, set up the boundary walk
        ST_IDLE: begin
          // a bad query answers right away
          done <= start && (req_type == REQ_RANGE_SUM) && !range_ok;
          if (start) begin
            k  <= amount;
            op <= OP_S;
            case (req_type)
              REQ_POINT_ADD: begin
                if (pos_ok) begin
                  s        <= {1'b1, left_pos};
                  t        <= {1'b1, left_pos};
                  cl       <= CNT_W'(1);
                  cr       <= '0;
                  phase2   <= 1'b1;
                  is_query <= 1'b0;
                  state    <= ST_LEVEL;
                end
              end
              REQ_RANGE_ADD, REQ_RANGE_SUM: begin
                if (range_ok) begin
                  s        <= {1'b1, left_pos} - NODE_W'(1);
                  t        <= {1'b1, right_pos} + NODE_W'(1);
                  cl       <= '0;
                  cr       <= '0;
                  len      <= CNT_W'(1);
                  phase2   <= 1'b0;
                  is_query <= (req_type == REQ_RANGE_SUM);
                  state    <= ST_LEVEL;
                end else if (req_type == REQ_RANGE_SUM) begin
                  range_sum <= '0;
                  status    <= STATUS_BAD;
                end
              end
              default: begin
              end
            endcase
          end
        end

        // loop tests: split walk, then the shared climb to the root
        ST_LEVEL: begin
          op <= OP_S;
          if (!phase2 && ((s ^ t ^ NODE_W'(1)) != '0)) begin
            done  <= 1'b0;
            state <= ST_ISSUE;
          end else if (s != '0) begin
            done   <= 1'b0;
            phase2 <= 1'b1;
            state  <= ST_ISSUE;
          end else begin
            done <= is_query;
            if (is_query) begin
              range_sum <= acc;
              status    <= STATUS_OK;
            end
            state <= ST_IDLE;
          end
        end

        ST_ISSUE: begin
          done  <= 1'b0;
          state <= op_mul ? ST_MUL : ST_ADD;
        end

        ST_MUL: begin
          done  <= 1'b0;
          state <= ST_ADD;
        end

        // write back or accumulate, then next access or next level
        ST_ADD: begin
          done <= 1'b0;
          if (op_more) begin
            op    <= op_nxt;
            state <= ST_ISSUE;
          end else begin
            if (!phase2) begin
              if (!s[0]) begin
                cl <= cl + len;
              end
              if (t[0]) begin
                cr <= cr + len;
              end
              len <= {len[CNT_W-2:0], 1'b0};
            end
            s     <= s >> 1;
            t     <= t >> 1;
            state <= ST_LEVEL;
          end
        end

        default: begin
          done  <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
